@@ rtl/rle_pkg.sv @@
package rle_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int TOTAL_W        = 20;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_INDEX_W    = 1;
  localparam int BYTE_W         = 8;
  localparam int VALUE_W        = 16;
  localparam int LENGTH_W       = 8;
  localparam int STATUS_W       = 2;

  localparam logic [BYTE_W-1:0] CMD_RAW     = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_RUN_MIN = 8'd2;
  localparam logic [BYTE_W-1:0] CMD_RUN_MAX = 8'd250;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL = 1'd1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLIPPED = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CMD    = 2'd1,
    PH_LO     = 2'd2,
    PH_HI     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [LENGTH_W-1:0] length;
    logic                done;
    logic [STATUS_W-1:0] status;
  } run_t;

endpackage

@@ rtl/rle_run_decoder_top.sv @@
// A result is registered on out_*, or in the skid register while the output is stalled.
// Throughput: one input beat per cycle while in_ready is high; state updates in one pass.
// A two-entry output (result register plus skid register) keeps input flowing
// while a result waits; in_ready drops only while the skid register is full.
// Reset (rst_n low, synchronous): await a header, counts and config cleared, no result pending.
module rle_run_decoder_top #(
  parameter int COUNT_BITS = rle_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rle_pkg::BYTE_W-1:0]       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rle_pkg::VALUE_W-1:0]      out_run_value,
  output logic [rle_pkg::LENGTH_W-1:0]     out_run_length,
  output logic                             out_block_done,
  output logic [rle_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_we,
  input  logic [rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rle_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rle_pkg::*;

  // Configuration
  logic               wide_r;
  logic [TOTAL_W-1:0] total_r;

  // Decoder state
  phase_t                phase_r, phase_nxt;
  logic                  compressed_r, compressed_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0]     pending_r, pending_nxt;
  logic [BYTE_W-1:0]     hold_r, hold_nxt;

  // Output side
  logic out_valid_r, skid_valid_r;
  run_t out_res_r, skid_res_r;

  logic                  in_fire;
  logic                  res_vld;
  run_t                  res;
  logic [COUNT_BITS-1:0] total_m;
  logic [COUNT_BITS-1:0] remaining;
  logic [COUNT_BITS-1:0] want_ext;
  logic [COUNT_BITS-1:0] fin_count;
  logic [BYTE_W-1:0]     want;
  logic                  clip;
  logic                  fin_done;
  logic                  cmd_legal;
  logic                  finish;

  // Total is taken modulo 2^COUNT_BITS.
  generate
    if (COUNT_BITS > TOTAL_W) begin : g_total_ext
      assign total_m = {{(COUNT_BITS-TOTAL_W){1'b0}}, total_r};
    end else if (COUNT_BITS == TOTAL_W) begin : g_total_eq
      assign total_m = total_r;
    end else begin : g_total_cut
      assign total_m = total_r[COUNT_BITS-1:0];
    end
  endgenerate

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // Run closing math: requested length, clip to what is left, advance count.
  always_comb begin
    want      = (compressed_r && (pending_r != CMD_RAW)) ? pending_r : BYTE_W'(1);
    want_ext  = COUNT_BITS'(want);
    remaining = (total_m > count_r) ? (total_m - count_r) : '0;
    clip      = (want_ext > remaining);
    fin_count = clip ? (count_r + remaining) : (count_r + want_ext);
    fin_done  = (fin_count >= total_m);
    cmd_legal = (in_byte inside {CMD_RAW, [CMD_RUN_MIN:CMD_RUN_MAX]});
    finish    = ((phase_r == PH_LO) && !wide_r) || (phase_r == PH_HI);
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (total_m != '0) begin
          phase_nxt = (in_byte != '0) ? PH_CMD : PH_LO;
        end
      end
      PH_CMD: begin
        if (cmd_legal) begin
          phase_nxt = PH_LO;
        end
      end
      PH_LO: begin
        if (wide_r) begin
          phase_nxt = PH_HI;
        end else begin
          phase_nxt = fin_done ? PH_HEADER : (compressed_r ? PH_CMD : PH_LO);
        end
      end
      PH_HI: begin
        phase_nxt = fin_done ? PH_HEADER : (compressed_r ? PH_CMD : PH_LO);
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  // Datapath updates and the result of this beat
  always_comb begin
    compressed_nxt = compressed_r;
    count_nxt      = count_r;
    pending_nxt    = pending_r;
    hold_nxt       = hold_r;
    res_vld        = 1'b0;
    res            = '0;
    case (phase_r)
      PH_HEADER: begin
        compressed_nxt = (in_byte != '0);
        count_nxt      = '0;
        pending_nxt    = CMD_RAW;
        if (total_m == '0) begin
          // empty block: report done with nothing to emit
          res_vld    = 1'b1;
          res.done   = 1'b1;
          res.status = ST_OK;
        end
      end
      PH_CMD: begin
        if (cmd_legal) begin
          pending_nxt = in_byte;
        end else begin
          res_vld    = 1'b1;
          res.status = ST_ILLEGAL;
        end
      end
      PH_LO: begin
        if (wide_r) begin
          hold_nxt = in_byte;
        end
      end
      PH_HI: begin
        hold_nxt = hold_r;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
    if (finish) begin
      count_nxt  = fin_count;
      res_vld    = 1'b1;
      res.value  = (phase_r == PH_HI) ? {in_byte, hold_r} : {{(VALUE_W-BYTE_W){1'b0}}, in_byte};
      res.length = clip ? remaining[LENGTH_W-1:0] : want;
      res.done   = fin_done;
      res.status = clip ? ST_CLIPPED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r       <= 1'b0;
      total_r      <= '0;
      phase_r      <= PH_HEADER;
      compressed_r <= 1'b0;
      count_r      <= '0;
      pending_r    <= '0;
      hold_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDE:  wide_r  <= cfg_data[0];
          CFG_TOTAL: total_r <= cfg_data[TOTAL_W-1:0];
          default:   wide_r  <= wide_r;
        endcase
      end
      // advance the decoder only on an accepted beat
      if (in_fire) begin
        phase_r      <= phase_nxt;
        compressed_r <= compressed_nxt;
        count_r      <= count_nxt;
        pending_r    <= pending_nxt;
        hold_r       <= hold_nxt;
      end
    end
  end

  // Output register with skid: a new result lands in the skid register when
  // the output register holds a beat that is not taken this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && res_vld;
      end
    end else if (in_fire && res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (in_fire && res_vld) begin
      skid_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_value  = out_res_r.value;
  assign out_run_length = out_res_r.length;
  assign out_block_done = out_res_r.done;
  assign out_status     = out_res_r.status;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while output register is empty");

  a_clip_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_CLIPPED)) |-> out_res_r.done)
    else $error("clipped run does not end the block");

  a_illegal_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_ILLEGAL)) |->
      ((out_res_r.length == '0) && !out_res_r.done))
    else $error("illegal command result carries a run");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.length <= CMD_RUN_MAX))
    else $error("run length out of range");

  a_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_HEADER) && (total_m == '0)) |=>
      (out_valid_r && phase_r == PH_HEADER))
    else $error("empty block header gave no result");

endmodule
